// File: rtl/etu_pkg.sv
`timescale 1ns / 1ps

package etu_pkg;

  localparam int FRAC_BITS  = 40;
  localparam int WORD_BITS  = 48;
  localparam int COORD_BITS = 12;

  localparam int OFS_BITS   = 48;
  localparam int STEP_BITS  = 47;
  localparam int SIZE_BITS  = 13;
  localparam int ITER_BITS  = 16;
  localparam int LIMIT_BITS = 47;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 48;

  localparam int HALF_BITS  = (WORD_BITS + 1) / 2;
  localparam int MAG_BITS   = 2 * HALF_BITS;
  localparam int ACC_BITS   = 4 * HALF_BITS;
  localparam int D_BITS     = (COORD_BITS + 2 > SIZE_BITS + 1) ? COORD_BITS + 2 : SIZE_BITS + 1;
  localparam int CPROD_BITS = D_BITS + STEP_BITS + 1;
  localparam int W1_BITS    = (CPROD_BITS > OFS_BITS) ? CPROD_BITS : OFS_BITS;
  localparam int WIDE_BITS  = ((W1_BITS > WORD_BITS) ? W1_BITS : WORD_BITS) + 1;
  localparam int CMP_BITS   = (WORD_BITS > LIMIT_BITS) ? WORD_BITS : LIMIT_BITS;
  localparam int MSTEP_BITS = 2;

  localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [ACC_BITS-1:0] ACC_WMAX = ACC_BITS'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam logic [ACC_BITS-1:0] ACC_WMIN_MAG = ACC_BITS'({1'b1, {(WORD_BITS-1){1'b0}}});

  localparam logic [CFG_ADDR_BITS-1:0] REG_OFFSET_RE     = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_OFFSET_IM     = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_PIXEL_STEP    = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SCREEN_WIDTH  = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SCREEN_HEIGHT = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_ITER      = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ESCAPE_LIMIT  = 3'd6;

  localparam logic signed [OFS_BITS-1:0] OFFSET_RE_RST     = -48'sd439804651110;
  localparam logic signed [OFS_BITS-1:0] OFFSET_IM_RST     = 48'sd0;
  localparam logic [STEP_BITS-1:0]       PIXEL_STEP_RST    = 47'd7233629130;
  localparam logic [SIZE_BITS-1:0]       SCREEN_WIDTH_RST  = 13'd760;
  localparam logic [SIZE_BITS-1:0]       SCREEN_HEIGHT_RST = 13'd540;
  localparam logic [ITER_BITS-1:0]       MAX_ITER_RST      = 16'd100;
  localparam logic [LIMIT_BITS-1:0]      ESCAPE_LIMIT_RST  = 47'd10995116277760;

  typedef struct packed {
    logic signed [OFS_BITS-1:0] offset_re;
    logic signed [OFS_BITS-1:0] offset_im;
    logic [STEP_BITS-1:0]       pixel_step;
    logic [SIZE_BITS-1:0]       screen_width;
    logic [SIZE_BITS-1:0]       screen_height;
    logic [ITER_BITS-1:0]       max_iterations;
    logic [LIMIT_BITS-1:0]      escape_limit;
  } etu_cfg_t;

  typedef struct packed {
    logic                  ld_pix;
    logic                  coord_mul;
    logic                  coord_mul_im;
    logic                  coord_add;
    logic                  coord_add_im;
    logic                  mul_load;
    logic                  mul_step;
    logic [MSTEP_BITS-1:0] mul_idx;
    logic                  mul_fin;
    logic                  eval;
    logic                  upd;
  } etu_cmd_t;

  function automatic logic signed [WORD_BITS-1:0] sat_wide(
    input logic signed [WIDE_BITS-1:0] v
  );
    logic signed [WORD_BITS-1:0] r;
    if (v > WIDE_BITS'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (v < WIDE_BITS'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] sat_add(
    input logic signed [WORD_BITS-1:0] a,
    input logic signed [WORD_BITS-1:0] b
  );
    logic [WORD_BITS:0] s;
    logic signed [WORD_BITS-1:0] r;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      r = s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end else begin
      r = s[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/etu_pix_if.sv
`timescale 1ns / 1ps

interface etu_pix_if import etu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// File: rtl/etu_res_if.sv
`timescale 1ns / 1ps

interface etu_res_if import etu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ITER_BITS-1:0] escape_count;
  logic                 in_set;

  modport source (output valid, output escape_count, output in_set, input ready);
  modport sink (input valid, input escape_count, input in_set, output ready);
endinterface

// File: rtl/etu_cfg.sv
`timescale 1ns / 1ps

module etu_cfg import etu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output etu_cfg_t                 cfg
);

  etu_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_re      <= OFFSET_RE_RST;
      cfg_r.offset_im      <= OFFSET_IM_RST;
      cfg_r.pixel_step     <= PIXEL_STEP_RST;
      cfg_r.screen_width   <= SCREEN_WIDTH_RST;
      cfg_r.screen_height  <= SCREEN_HEIGHT_RST;
      cfg_r.max_iterations <= MAX_ITER_RST;
      cfg_r.escape_limit   <= ESCAPE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_OFFSET_RE: begin
          cfg_r.offset_re <= cfg_wdata[OFS_BITS-1:0];
        end
        REG_OFFSET_IM: begin
          cfg_r.offset_im <= cfg_wdata[OFS_BITS-1:0];
        end
        REG_PIXEL_STEP: begin
          cfg_r.pixel_step <= cfg_wdata[STEP_BITS-1:0];
        end
        REG_SCREEN_WIDTH: begin
          cfg_r.screen_width <= cfg_wdata[SIZE_BITS-1:0];
        end
        REG_SCREEN_HEIGHT: begin
          cfg_r.screen_height <= cfg_wdata[SIZE_BITS-1:0];
        end
        REG_MAX_ITER: begin
          cfg_r.max_iterations <= cfg_wdata[ITER_BITS-1:0];
        end
        REG_ESCAPE_LIMIT: begin
          cfg_r.escape_limit <= cfg_wdata[LIMIT_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/etu_mul.sv
`timescale 1ns / 1ps

module etu_mul import etu_pkg::*; (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  logic [MSTEP_BITS-1:0]       idx,
  input  logic                        dbl,
  input  logic signed [WORD_BITS-1:0] a,
  input  logic signed [WORD_BITS-1:0] b,
  output logic signed [WORD_BITS-1:0] prod
);

  logic [MAG_BITS-1:0]  ma_r;
  logic [MAG_BITS-1:0]  mb_r;
  logic                 neg_r;
  logic [ACC_BITS-1:0]  acc_r;

  logic [WORD_BITS-1:0] mag_a;
  logic [WORD_BITS-1:0] mag_b;
  logic [HALF_BITS-1:0] a_dig;
  logic [HALF_BITS-1:0] b_dig;
  logic [MAG_BITS-1:0]  pp;
  logic [ACC_BITS-1:0]  pp_sh;
  logic [ACC_BITS-1:0]  sh;

  assign mag_a = a[WORD_BITS-1] ? (~a + 1'b1) : a;
  assign mag_b = b[WORD_BITS-1] ? (~b + 1'b1) : b;

  assign a_dig = idx[1] ? ma_r[MAG_BITS-1:HALF_BITS] : ma_r[HALF_BITS-1:0];
  assign b_dig = idx[0] ? mb_r[MAG_BITS-1:HALF_BITS] : mb_r[HALF_BITS-1:0];
  assign pp    = a_dig * b_dig;

  always_comb begin
    if (idx[1] & idx[0]) begin
      pp_sh = ACC_BITS'({pp, {MAG_BITS{1'b0}}});
    end else if (idx[1] ^ idx[0]) begin
      pp_sh = ACC_BITS'({pp, {HALF_BITS{1'b0}}});
    end else begin
      pp_sh = ACC_BITS'(pp);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ma_r  <= MAG_BITS'(mag_a);
      mb_r  <= MAG_BITS'(mag_b);
      neg_r <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
      acc_r <= '0;
    end else if (step) begin
      acc_r <= acc_r + pp_sh;
    end
  end

  // The product magnitude is truncated before the sign is applied.
  assign sh = dbl ? (acc_r >> (FRAC_BITS - 1)) : (acc_r >> FRAC_BITS);

  always_comb begin
    if (neg_r) begin
      if (sh > ACC_WMIN_MAG) begin
        prod = WORD_MIN;
      end else begin
        prod = WORD_BITS'(ACC_BITS'(0) - sh);
      end
    end else begin
      if (sh > ACC_WMAX) begin
        prod = WORD_MAX;
      end else begin
        prod = WORD_BITS'(sh);
      end
    end
  end

endmodule

// File: rtl/etu_datapath.sv
`timescale 1ns / 1ps

module etu_datapath import etu_pkg::*; (
  input  logic                  clk,
  input  etu_cfg_t              cfg,
  input  etu_cmd_t              cmd,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  output logic                  escape
);

  logic [COORD_BITS-1:0]        px_r;
  logic [COORD_BITS-1:0]        py_r;
  logic signed [CPROD_BITS-1:0] coord_prod_r;
  logic signed [CPROD_BITS-1:0] coord_prod_nxt;
  logic signed [WORD_BITS-1:0]  c_re_r;
  logic signed [WORD_BITS-1:0]  c_im_r;
  logic signed [WORD_BITS-1:0]  re_r;
  logic signed [WORD_BITS-1:0]  im_r;
  logic signed [WORD_BITS-1:0]  xx_r;
  logic signed [WORD_BITS-1:0]  yy_r;
  logic signed [WORD_BITS-1:0]  xy_r;
  logic signed [WORD_BITS-1:0]  diff_r;

  logic [COORD_BITS-1:0]        coord_pix;
  logic [SIZE_BITS-1:0]         coord_size;
  logic signed [D_BITS-1:0]     coord_d;
  logic signed [CPROD_BITS-1:0] coord_half;
  logic signed [OFS_BITS-1:0]   coord_ofs;
  logic signed [WORD_BITS-1:0]  coord_val;
  logic signed [WORD_BITS-1:0]  xx_prod;
  logic signed [WORD_BITS-1:0]  yy_prod;
  logic signed [WORD_BITS-1:0]  xy_prod;
  logic [WORD_BITS-1:0]         esc_sum;
  logic [WORD_BITS-1:0]         esc_sat;

  assign coord_pix      = cmd.coord_mul_im ? py_r : px_r;
  assign coord_size     = cmd.coord_mul_im ? cfg.screen_height : cfg.screen_width;
  assign coord_d        = $signed(D_BITS'({coord_pix, 1'b0}) - D_BITS'(coord_size));
  assign coord_prod_nxt = coord_d * $signed({1'b0, cfg.pixel_step});

  // An arithmetic shift gives the floor of the half product.
  assign coord_half = coord_prod_r >>> 1;
  assign coord_ofs  = cmd.coord_add_im ? cfg.offset_im : cfg.offset_re;
  assign coord_val  = sat_add(sat_wide(WIDE_BITS'(coord_half)),
                              sat_wide(WIDE_BITS'(coord_ofs)));

  etu_mul u_mul_xx (
    .clk  (clk),
    .load (cmd.mul_load),
    .step (cmd.mul_step),
    .idx  (cmd.mul_idx),
    .dbl  (1'b0),
    .a    (re_r),
    .b    (re_r),
    .prod (xx_prod)
  );

  etu_mul u_mul_yy (
    .clk  (clk),
    .load (cmd.mul_load),
    .step (cmd.mul_step),
    .idx  (cmd.mul_idx),
    .dbl  (1'b0),
    .a    (im_r),
    .b    (im_r),
    .prod (yy_prod)
  );

  etu_mul u_mul_xy (
    .clk  (clk),
    .load (cmd.mul_load),
    .step (cmd.mul_step),
    .idx  (cmd.mul_idx),
    .dbl  (1'b1),
    .a    (re_r),
    .b    (im_r),
    .prod (xy_prod)
  );

  // Both squares are non-negative, so their sum fits the word unsigned.
  // The sum saturates at the largest word value before the compare.
  assign esc_sum = WORD_BITS'($unsigned(xx_r)) + WORD_BITS'($unsigned(yy_r));
  assign esc_sat = esc_sum[WORD_BITS-1] ? WORD_MAX : esc_sum;
  assign escape  = CMP_BITS'(esc_sat) > CMP_BITS'(cfg.escape_limit);

  always_ff @(posedge clk) begin
    if (cmd.ld_pix) begin
      px_r <= pixel_x;
      py_r <= pixel_y;
    end
    if (cmd.coord_mul) begin
      coord_prod_r <= coord_prod_nxt;
    end
    if (cmd.coord_add) begin
      if (cmd.coord_add_im) begin
        c_im_r <= coord_val;
        im_r   <= coord_val;
      end else begin
        c_re_r <= coord_val;
        re_r   <= coord_val;
      end
    end
    if (cmd.mul_fin) begin
      xx_r <= xx_prod;
      yy_r <= yy_prod;
      xy_r <= xy_prod;
    end
    if (cmd.eval) begin
      diff_r <= xx_r - yy_r;
    end
    if (cmd.upd) begin
      re_r <= sat_add(diff_r, c_re_r);
      im_r <= sat_add(xy_r, c_im_r);
    end
  end

endmodule

// File: rtl/etu_ctrl.sv
`timescale 1ns / 1ps

module etu_ctrl import etu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ITER_BITS-1:0] out_count,
  output logic                 out_in_set,
  input  logic [ITER_BITS-1:0] max_iterations,
  input  logic                 escape,
  output etu_cmd_t             cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CRE,
    S_CIM,
    S_CFIN,
    S_LOAD,
    S_MUL,
    S_FIN,
    S_EVAL,
    S_UPD,
    S_DONE
  } state_t;

  state_t                state_r;
  state_t                state_nxt;
  logic [ITER_BITS-1:0]  iter_r;
  logic [ITER_BITS-1:0]  iter_nxt;
  logic [MSTEP_BITS-1:0] mstep_r;
  logic [MSTEP_BITS-1:0] mstep_nxt;
  logic                  res_in_set_r;
  logic                  res_in_set_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [ITER_BITS-1:0]  out_count_r;
  logic [ITER_BITS-1:0]  out_count_nxt;
  logic                  out_in_set_r;
  logic                  out_in_set_nxt;
  logic                  last_iter;

  assign last_iter = ((ITER_BITS+1)'(iter_r) + 1'b1) == (ITER_BITS+1)'(max_iterations);

  always_comb begin
    state_nxt      = state_r;
    iter_nxt       = iter_r;
    mstep_nxt      = mstep_r;
    res_in_set_nxt = res_in_set_r;
    out_valid_nxt  = out_valid_r;
    out_count_nxt  = out_count_r;
    out_in_set_nxt = out_in_set_r;
    cmd            = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        cmd.ld_pix = in_valid;
        if (in_valid) begin
          state_nxt = S_CRE;
        end
      end
      S_CRE: begin
        cmd.coord_mul = 1'b1;
        state_nxt     = S_CIM;
      end
      S_CIM: begin
        cmd.coord_mul    = 1'b1;
        cmd.coord_mul_im = 1'b1;
        cmd.coord_add    = 1'b1;
        state_nxt        = S_CFIN;
      end
      S_CFIN: begin
        cmd.coord_add    = 1'b1;
        cmd.coord_add_im = 1'b1;
        iter_nxt         = '0;
        if (max_iterations == '0) begin
          res_in_set_nxt = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.mul_load = 1'b1;
        mstep_nxt    = '0;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.mul_idx  = mstep_r;
        mstep_nxt    = mstep_r + 1'b1;
        if (&mstep_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.mul_fin = 1'b1;
        state_nxt   = S_EVAL;
      end
      S_EVAL: begin
        if (escape) begin
          res_in_set_nxt = 1'b0;
          state_nxt      = S_DONE;
        end else begin
          cmd.eval  = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (last_iter) begin
          res_in_set_nxt = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          iter_nxt  = iter_r + 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_count_nxt  = res_in_set_r ? '0 : iter_r;
          out_in_set_nxt = res_in_set_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      iter_r       <= '0;
      mstep_r      <= '0;
      res_in_set_r <= 1'b0;
      out_valid_r  <= 1'b0;
      out_count_r  <= '0;
      out_in_set_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      iter_r       <= iter_nxt;
      mstep_r      <= mstep_nxt;
      res_in_set_r <= res_in_set_nxt;
      out_valid_r  <= out_valid_nxt;
      out_count_r  <= out_count_nxt;
      out_in_set_r <= out_in_set_nxt;
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_count  = out_count_r;
  assign out_in_set = out_in_set_r;

endmodule

// File: rtl/mandelbrot_escape_time_unit.sv
`timescale 1ns / 1ps

// Escape-time unit: each input word is one pixel, which is mapped to a point c
// of the complex plane and iterated as z = z*z + c from z = c in signed Q8.40.
// It works on one pixel at a time. The pixel is mapped on a shared 14 by 48
// bit multiplier, and each iteration steps through the four 24 by 24 bit
// partial products that each of the three squaring and cross-product
// multipliers accumulates. The result sits in an output register, so the next
// pixel is accepted while it waits. Configuration must be written only while
// the unit is idle; the unit itself does not enforce this.
module mandelbrot_escape_time_unit import etu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  etu_pix_if.sink                  in_pix,
  etu_res_if.source                out_res,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  etu_cfg_t cfg;
  etu_cmd_t cmd;
  logic     escape;

  etu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  etu_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_pix.valid),
    .in_ready       (in_pix.ready),
    .out_valid      (out_res.valid),
    .out_ready      (out_res.ready),
    .out_count      (out_res.escape_count),
    .out_in_set     (out_res.in_set),
    .max_iterations (cfg.max_iterations),
    .escape         (escape),
    .cmd            (cmd)
  );

  etu_datapath u_datapath (
    .clk     (clk),
    .cfg     (cfg),
    .cmd     (cmd),
    .pixel_x (in_pix.pixel_x),
    .pixel_y (in_pix.pixel_y),
    .escape  (escape)
  );

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_pix.valid && in_pix.ready) |=> !in_pix.ready
  ) else $error("input accepted while a pixel is in progress");

  a_in_set_zero_count: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.in_set) |-> (out_res.escape_count == '0)
  ) else $error("in-set result carries a nonzero escape count");

  a_count_in_budget: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.in_set) |-> (out_res.escape_count < cfg.max_iterations)
  ) else $error("escape count outside the iteration budget");

  a_single_step_cmd: assert property (
    @(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ld_pix, cmd.mul_load, cmd.mul_step, cmd.mul_fin, cmd.eval, cmd.upd})
  ) else $error("conflicting datapath commands");

endmodule
